>>> sv/mpcm_pkg.sv
// Shared types, codes and helpers for the MIDI packet command mapper.
package mpcm_pkg;

    localparam int unsigned NOTE_W  = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_NOTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREVIOUS_NOTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_NOTE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK_BASE    = 2'd3;

    localparam logic [NOTE_W-1:0] TOGGLE_NOTE_RST   = 7'd59;
    localparam logic [NOTE_W-1:0] PREVIOUS_NOTE_RST = 7'd60;
    localparam logic [NOTE_W-1:0] NEXT_NOTE_RST     = 7'd62;
    localparam logic [NOTE_W-1:0] QUICK_BASE_RST    = 7'd70;

    // report kinds
    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_CC       = 2'd2;

    // lamp commands
    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_TOGGLE     = 3'd1;
    localparam logic [2:0] CMD_PREV       = 3'd2;
    localparam logic [2:0] CMD_NEXT       = 3'd3;
    localparam logic [2:0] CMD_MODE       = 3'd4;
    localparam logic [2:0] CMD_BRIGHTNESS = 3'd5;

    // status high nibbles and controller numbers
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CC       = 4'hB;
    localparam logic [NOTE_W-1:0] CC_VOLUME = 7'h07;
    localparam logic [NOTE_W-1:0] CC_PAN    = 7'h0A;

    // 100/127 as a 16-bit fraction, rounded up; exact for 8-bit inputs
    localparam logic [15:0] BRIGHT_RECIP = 16'd51604;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] lookahead_byte;
        logic       has_lookahead;
        logic       packet_start;
    } in_word_t;

    typedef struct packed {
        logic [1:0] report_kind;
        logic [3:0] channel;
        logic [6:0] number;
        logic [7:0] value;
        logic [2:0] command;
        logic [7:0] command_arg;
    } out_word_t;

    typedef struct packed {
        logic [NOTE_W-1:0] toggle_note;
        logic [NOTE_W-1:0] previous_note;
        logic [NOTE_W-1:0] next_note;
        logic [NOTE_W-1:0] quick_base_note;
    } cfg_t;

    // floor(val * 100 / 127)
    function automatic logic [7:0] bright_arg(input logic [7:0] val);
        logic [23:0] prod;
        prod = {16'd0, val} * {8'd0, BRIGHT_RECIP};
        return prod[23:16];
    endfunction

endpackage

>>> sv/midi_packet_command_mapper_unit.sv
// Top level of the BLE MIDI packet command mapper.
//
// Input channel (in_valid / in_stall / in_word): one packet byte per word,
// with its lookahead byte, a lookahead-present flag and a packet-start flag.
// Output channel (out_valid / out_stall / out_word): note on, note off and
// controller 7/10 reports, each with its lamp command and argument.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// toggle, previous, next and quick-mode base notes; cfg_ready is always high.
// Write configuration only while no word is in flight.
// An accepted word is registered in the input register, then parsed into the
// result register, which drives out_valid. One word per cycle is taken while
// out_stall holds no result; the running status and consume flag update as
// each word is parsed, which sets that rate. Words that give no result
// (status, timestamp, value bytes) are absorbed without an output word.
// When out_stall holds a result, the parse stage waits and in_stall rises
// once the input register is full. Reset clears status, flags, valids and
// restores the default note assignments.
module midi_packet_command_mapper_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mpcm_pkg::in_word_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mpcm_pkg::out_word_t                 out_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mpcm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mpcm_pkg::NOTE_W-1:0]         cfg_data
);
    import mpcm_pkg::*;

    logic     in_valid_reg, in_valid_next;
    in_word_t in_word_reg;
    logic     advance;
    cfg_t     cfg;

    assign in_stall      = in_valid_reg && !advance;
    assign in_valid_next = in_stall ? in_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_word;
    end

    mpcm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpcm_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_valid_reg),
        .item       (in_word_reg),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

>>> sv/mpcm_cfg_regs.sv
// Configuration registers: note assignments for the lamp commands.
module mpcm_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mpcm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mpcm_pkg::NOTE_W-1:0]         cfg_data,
    output mpcm_pkg::cfg_t                      cfg
);
    import mpcm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TOGGLE_NOTE:   cfg_next.toggle_note     = cfg_data;
                CFG_PREVIOUS_NOTE: cfg_next.previous_note   = cfg_data;
                CFG_NEXT_NOTE:     cfg_next.next_note       = cfg_data;
                CFG_QUICK_BASE:    cfg_next.quick_base_note = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.toggle_note     <= TOGGLE_NOTE_RST;
            cfg_reg.previous_note   <= PREVIOUS_NOTE_RST;
            cfg_reg.next_note       <= NEXT_NOTE_RST;
            cfg_reg.quick_base_note <= QUICK_BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/mpcm_parser.sv
// Parse stage: running status, consume flag and the result register.
module mpcm_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mpcm_pkg::cfg_t        cfg,
    input  logic                  item_valid,
    input  mpcm_pkg::in_word_t    item,
    output logic                  advance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mpcm_pkg::out_word_t   out_word
);
    import mpcm_pkg::*;

    logic [7:0] status_reg, status_next;
    logic       consume_reg, consume_next;
    logic       res_valid_reg, res_valid_next;
    out_word_t  res_word_reg;

    logic       fire;
    logic       has_result;
    out_word_t  res;
    logic [7:0] status_cur;
    logic       consume_cur;
    logic [7:0] val;
    logic [6:0] note;
    logic [7:0] quick_end;
    logic [3:0] quick_off;
    logic       b_hi;

    // the output register frees up this cycle, or is already empty
    assign advance   = !res_valid_reg || !out_stall;
    assign fire      = item_valid && advance;
    assign out_valid = res_valid_reg;
    assign out_word  = res_word_reg;

    always_comb
    begin
        status_cur  = item.packet_start ? 8'd0 : status_reg;
        consume_cur = item.packet_start ? 1'b0 : consume_reg;
        val         = item.has_lookahead ? item.lookahead_byte : 8'd0;
        note        = item.data_byte[6:0];
        b_hi        = item.data_byte[7];
        quick_end   = {1'b0, cfg.quick_base_note} + 8'd8;
        // only needed inside the quick range, where the offset is 0..7
        quick_off   = note[3:0] - cfg.quick_base_note[3:0];

        status_next = status_cur;
        consume_next = consume_cur;
        has_result  = 1'b0;
        res.report_kind = KIND_NOTE_OFF;
        res.channel     = status_cur[3:0];
        res.number      = note;
        res.value       = val;
        res.command     = CMD_NONE;
        res.command_arg = 8'd0;

        priority if (consume_cur)
        begin
            consume_next = 1'b0;
        end
        else if (b_hi && item.has_lookahead && item.lookahead_byte[7])
        begin
            // timestamp byte: skipped
        end
        else if (b_hi)
        begin
            status_next = item.data_byte;
        end
        else if (status_cur == 8'd0)
        begin
            // data byte with no status
        end
        else if (status_cur[7:4] == ST_NOTE_OFF || status_cur[7:4] == ST_NOTE_ON)
        begin
            has_result   = 1'b1;
            status_next  = 8'd0;
            consume_next = item.has_lookahead;
            if (status_cur[7:4] == ST_NOTE_ON && val != 8'd0)
            begin
                res.report_kind = KIND_NOTE_ON;
                priority if (note == cfg.toggle_note)
                    res.command = CMD_TOGGLE;
                else if (note == cfg.previous_note)
                    res.command = CMD_PREV;
                else if (note == cfg.next_note)
                    res.command = CMD_NEXT;
                else if (note >= cfg.quick_base_note && {1'b0, note} < quick_end)
                begin
                    res.command     = CMD_MODE;
                    res.command_arg = {4'd0, quick_off + 4'd1};
                end
                else
                    res.command = CMD_NONE;
            end
        end
        else if (status_cur[7:4] == ST_CC && (note == CC_VOLUME || note == CC_PAN) && !b_hi)
        begin
            has_result      = 1'b1;
            status_next     = 8'd0;
            consume_next    = item.has_lookahead;
            res.report_kind = KIND_CC;
            res.channel     = 4'd0;
            if (note == CC_VOLUME)
            begin
                res.command     = CMD_BRIGHTNESS;
                res.command_arg = bright_arg(val);
            end
        end
        else
        begin
            status_next = 8'd0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = fire && has_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= 8'd0;
            consume_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                status_reg  <= status_next;
                consume_reg <= consume_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_result)
            res_word_reg <= res;
    end

endmodule

>>> sv/mpcm_checker.sv
// Port-level checks for the MIDI packet command mapper, bound to the top level.
module mpcm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  mpcm_pkg::out_word_t                 out_word
);
    import mpcm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // with the output empty the input never stalls
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // a fresh result traces back to an accepted input word
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without an accepted input word");

    // no command means no argument, and the kind is a known one
    a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.report_kind != 2'd3) &&
                      (out_word.command != CMD_NONE || out_word.command_arg == 8'd0))
        else $error("malformed result word");

endmodule

bind midi_packet_command_mapper_unit mpcm_checker u_mpcm_checker (.*);
